### rtl/owmr_pkg.sv
// ---------------------------------------------------------------------------
// owmr_pkg
// Shared constants and codes for the overwriting multi-reader byte ring.
// ---------------------------------------------------------------------------
package owmr_pkg;

   // Ring size must be a power of two: ring addresses are the low total bits.
   localparam int RING_BYTES  = 4096;
   localparam int NUM_READERS = 4;
   localparam int READ_BURST  = 16;

   localparam int RING_AW  = $clog2(RING_BYTES);
   localparam int TOTAL_W  = 64;
   localparam int DROP_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int FUNC_W   = 2;
   localparam int IDX_W    = 2;
   localparam int POS_W    = 16;
   localparam int RLEN_W   = 5;
   localparam int CNT_W    = $clog2(READ_BURST + 1);
   // width for datagram length vs ring size compares
   localparam int CMP_W    = (RING_AW + 1 > POS_W + 1) ? RING_AW + 1 : POS_W + 1;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

endpackage

### rtl/owmr_if.sv
// ---------------------------------------------------------------------------
// owmr_req_if / owmr_rsp_if
// Valid/ready channels carrying ring requests and read responses.
// ---------------------------------------------------------------------------
interface owmr_req_if;
   import owmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [IDX_W-1:0]    reader_index;
   logic [BYTE_W-1:0]   data_byte;
   logic [POS_W-1:0]    datagram_length;
   logic [RLEN_W-1:0]   read_length;

   modport source (output valid, func, reader_index, data_byte, datagram_length,
                   read_length, input ready);
   modport sink   (input valid, func, reader_index, data_byte, datagram_length,
                   read_length, output ready);
endinterface

interface owmr_rsp_if;
   import owmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   read_byte;
   logic                byte_valid;
   logic                last_result;
   logic [DROP_W-1:0]   dropped_bytes;

   modport source (output valid, read_byte, byte_valid, last_result, dropped_bytes,
                   input ready);
   modport sink   (input valid, read_byte, byte_valid, last_result, dropped_bytes,
                   output ready);
endinterface

### rtl/owmr_ram.sv
// ---------------------------------------------------------------------------
// owmr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module owmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### rtl/owmr_alu.sv
// ---------------------------------------------------------------------------
// owmr_alu
// Shared 64-bit add/subtract unit used by the write, bookkeeping and read steps.
// ---------------------------------------------------------------------------
module owmr_alu (
   input  logic [owmr_pkg::TOTAL_W-1:0] op_a,
   input  logic [owmr_pkg::TOTAL_W-1:0] op_b,
   input  logic                         sub,
   output logic [owmr_pkg::TOTAL_W-1:0] result
);
   import owmr_pkg::*;

   logic [TOTAL_W-1:0] op_b_x;

   assign op_b_x = sub ? ~op_b : op_b;
   assign result = op_a + op_b_x + TOTAL_W'(sub);
endmodule

### rtl/overwriting_multi_reader_ring.sv
// ---------------------------------------------------------------------------
// overwriting_multi_reader_ring
// Byte ring with an overwriting writer that never waits for free space, and several independent readers.
// ---------------------------------------------------------------------------
// A write or an open is taken while idle and the block stays ready for the
// next request. A read holds the request side through bookkeeping (lag,
// excess, overrun fixup), then per returned byte through RAM address,
// registered RAM data and response transfer, plus any response stall; a read
// that returns no byte gives its single response right after the bookkeeping,
// and one for an unknown reader skips it. The order follows from one shared
// 64-bit adder for every total update in turn and the registered RAM read port.
module overwriting_multi_reader_ring (
   input  logic       clock,
   input  logic       reset,
   owmr_req_if.sink   req_port,
   owmr_rsp_if.source rsp_port
);
   import owmr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LAG  = 3'd1;
   localparam logic [2:0] S_SKIP = 3'd2;
   localparam logic [2:0] S_OVR  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_CAP  = 3'd5;
   localparam logic [2:0] S_WAIT = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [TOTAL_W-1:0]  rt_ff [NUM_READERS];
   logic [TOTAL_W-1:0]  rt_in [NUM_READERS];
   logic [DROP_W-1:0]   drop_ff [NUM_READERS];
   logic [DROP_W-1:0]   drop_in [NUM_READERS];
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    want_ff, want_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]  lag_ff, lag_in;
   logic [TOTAL_W-1:0]  skip_ff, skip_in;
   logic                over_ff, over_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_bvalid_ff, out_bvalid_in;
   logic                out_last_ff, out_last_in;
   logic [DROP_W-1:0]   out_drop_ff, out_drop_in;

   logic                req_xfer;
   logic                rsp_xfer;
   logic                idx_ok;
   logic [CMP_W-1:0]    len_c;
   logic [POS_W:0]      pos_next;
   logic                keep;
   logic                ram_we;
   logic [BYTE_W-1:0]   ram_rdata;
   logic [TOTAL_W-1:0]  alu_a, alu_b, alu_sum;
   logic                alu_sub;
   logic [DROP_W:0]     drop_sum;
   logic [DROP_W-1:0]   drop_new;
   logic [TOTAL_W-1:0]  avail;
   logic [CNT_W-1:0]    n_bytes;

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_port.valid && req_port.ready;
   assign rsp_port.valid = (state_ff == S_WAIT);
   assign rsp_xfer       = rsp_port.valid && rsp_port.ready;

   assign rsp_port.read_byte     = out_byte_ff;
   assign rsp_port.byte_valid    = out_bvalid_ff;
   assign rsp_port.last_result   = out_last_ff;
   assign rsp_port.dropped_bytes = out_drop_ff;

   assign idx_ok = (32'(req_port.reader_index) < NUM_READERS);

   // datagram trimming: only the last RING_BYTES bytes of a datagram are kept
   assign len_c    = (req_port.datagram_length == '0) ? CMP_W'(1)
                                                      : CMP_W'(req_port.datagram_length);
   assign keep     = (len_c <= CMP_W'(RING_BYTES)) ||
                     (CMP_W'(pos_ff) >= len_c - CMP_W'(RING_BYTES));
   assign pos_next = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign ram_we   = req_xfer && (req_port.func == FUNC_WRITE) && keep;

   owmr_ram #(.WIDTH(BYTE_W), .DEPTH(RING_BYTES)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (total_ff[RING_AW-1:0]),
      .wdata (req_port.data_byte),
      .raddr (rt_ff[idx_ff][RING_AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (state_ff)
         S_LAG: begin
            alu_a = total_ff;  alu_b = rt_ff[idx_ff];        alu_sub = 1'b1;
         end
         S_SKIP: begin
            alu_a = lag_ff;    alu_b = TOTAL_W'(RING_BYTES); alu_sub = 1'b1;
         end
         S_OVR: begin
            alu_a = total_ff;  alu_b = TOTAL_W'(RING_BYTES); alu_sub = 1'b1;
         end
         S_RD: begin
            alu_a = rt_ff[idx_ff]; alu_b = TOTAL_W'(1);      alu_sub = 1'b0;
         end
         default: begin
            alu_a = total_ff;  alu_b = TOTAL_W'(1);          alu_sub = 1'b0;
         end
      endcase
   end

   owmr_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_sum)
   );

   // saturating drop count update, excess held in skip_ff
   assign drop_sum = {1'b0, drop_ff[idx_ff]} + {1'b0, skip_ff[DROP_W-1:0]};
   assign drop_new = ((skip_ff[TOTAL_W-1:DROP_W] != '0) || drop_sum[DROP_W]) ? '1
                                                                       : drop_sum[DROP_W-1:0];
   assign avail    = over_ff ? TOTAL_W'(RING_BYTES) : lag_ff;
   assign n_bytes  = (avail < TOTAL_W'(want_ff)) ? CNT_W'(avail) : want_ff;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      pos_in        = pos_ff;
      rt_in         = rt_ff;
      drop_in       = drop_ff;
      idx_in        = idx_ff;
      want_in       = want_ff;
      cnt_in        = cnt_ff;
      lag_in        = lag_ff;
      skip_in       = skip_ff;
      over_in       = over_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      out_drop_in   = out_drop_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_port.func)
                  FUNC_WRITE: begin
                     if (keep) begin
                        total_in = alu_sum;
                     end
                     pos_in = (CMP_W'(pos_next) >= len_c) ? '0 : pos_next[POS_W-1:0];
                  end
                  FUNC_OPEN: begin
                     if (idx_ok) begin
                        rt_in[req_port.reader_index] = total_ff;
                     end
                  end
                  FUNC_READ: begin
                     idx_in  = req_port.reader_index;
                     want_in = (32'(req_port.read_length) > READ_BURST)
                               ? CNT_W'(READ_BURST) : CNT_W'(req_port.read_length);
                     if (idx_ok) begin
                        state_in = S_LAG;
                     end else begin
                        out_byte_in   = '0;
                        out_bvalid_in = 1'b0;
                        out_last_in   = 1'b1;
                        out_drop_in   = '0;
                        state_in      = S_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LAG: begin
            lag_in   = alu_sum;
            state_in = S_SKIP;
         end
         S_SKIP: begin
            skip_in  = alu_sum;
            over_in  = (lag_ff > TOTAL_W'(RING_BYTES));
            state_in = S_OVR;
         end
         S_OVR: begin
            if (over_ff) begin
               rt_in[idx_ff]   = alu_sum;
               drop_in[idx_ff] = drop_new;
            end
            cnt_in = n_bytes;
            if (n_bytes == '0) begin
               out_byte_in   = '0;
               out_bvalid_in = 1'b0;
               out_last_in   = 1'b1;
               out_drop_in   = over_ff ? drop_new : drop_ff[idx_ff];
               state_in      = S_WAIT;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            rt_in[idx_ff] = alu_sum;
            cnt_in        = cnt_ff - CNT_W'(1);
            state_in      = S_CAP;
         end
         S_CAP: begin
            out_byte_in   = ram_rdata;
            out_bvalid_in = 1'b1;
            out_last_in   = (cnt_ff == '0);
            out_drop_in   = drop_ff[idx_ff];
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_xfer) begin
               state_in = out_last_ff ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         over_ff  <= 1'b0;
         for (int i = 0; i < NUM_READERS; i++) begin
            rt_ff[i]   <= '0;
            drop_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         over_ff  <= over_in;
         rt_ff    <= rt_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      want_ff       <= want_in;
      lag_ff        <= lag_in;
      skip_ff       <= skip_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
      out_drop_ff   <= out_drop_in;
   end

   // a response and a new request never share a cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_port.ready |-> !rsp_port.valid)
      else $error("request ready while a response is pending");

   // the write total moves only on a kept write byte
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !ram_we |=> total_ff == $past(total_ff))
      else $error("write total moved without a stored byte");

   a_total_inc: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> total_ff == $past(total_ff) + TOTAL_W'(1))
      else $error("write total did not advance on a stored byte");

   // the final response of an item hands control back to the request side
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_port.last_result) |=> req_port.ready)
      else $error("no return to idle after the last response");

   // a burst never counts past its limit
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (cnt_ff != '0) && (32'(cnt_ff) <= READ_BURST))
      else $error("burst counter out of range");

endmodule

### sim/overwriting_multi_reader_ring_test.sv
// ---------------------------------------------------------------------------
// overwriting_multi_reader_ring_test
// Drives writes, reader opens and read bursts into the byte ring, predicts
// every read response from a local copy of the ring and the reader totals,
// and checks the responses in order, field by field.
// ---------------------------------------------------------------------------
module overwriting_multi_reader_ring_test;
   import owmr_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PCT     = 19;
   localparam int RANDOM_ITEMS = 320;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  reader_index;
      logic [BYTE_W-1:0] data_byte;
      logic [POS_W-1:0]  datagram_length;
      logic [RLEN_W-1:0] read_length;
   } ring_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              byte_valid;
      logic              last_result;
      logic [DROP_W-1:0] dropped_bytes;
   } ring_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   owmr_req_if req_if();
   owmr_rsp_if rsp_if();

   overwriting_multi_reader_ring i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stimulus and expected responses
   ring_req_type request_feed[$];
   ring_rsp_type read_replies[$];
   ring_req_type on_offer;

   // local copy of the ring state
   logic [BYTE_W-1:0]  ring_copy [RING_BYTES];
   logic [TOTAL_W-1:0] written_total = '0;
   logic [TOTAL_W-1:0] reader_pos   [NUM_READERS];
   logic [DROP_W-1:0]  reader_drops [NUM_READERS];
   int unsigned        dgram_pos = 0;

   int  items_taken = 0;
   int  fault_count = 0;
   int  idle_cycles = 0;
   int  steady_from = 0;
   int  steady_to   = 0;
   int  hold_at     = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   bit  steady;

   assign steady = (items_taken >= steady_from) && (items_taken < steady_to);

   initial begin
      for (int i = 0; i < NUM_READERS; i++) begin
         reader_pos[i]   = '0;
         reader_drops[i] = '0;
      end
   end

   task automatic feed_item(input logic [FUNC_W-1:0] f, input int idx, input int value,
                            input int len, input int rlen);
      ring_req_type r;
      r.func            = f;
      r.reader_index    = idx[IDX_W-1:0];
      r.data_byte       = value[BYTE_W-1:0];
      r.datagram_length = len[POS_W-1:0];
      r.read_length     = rlen[RLEN_W-1:0];
      request_feed.push_back(r);
   endtask

   // Advance the local ring for one accepted request, queue the read responses.
   task automatic model_request(input ring_req_type r);
      int unsigned        len;
      int unsigned        want;
      int unsigned        n;
      int unsigned        rd;
      logic [TOTAL_W-1:0] lag;
      logic [TOTAL_W-1:0] avail;
      logic [TOTAL_W-1:0] skipped;
      case (r.func)
         FUNC_WRITE: begin
            len = (r.datagram_length == '0) ? 1 : r.datagram_length;
            // only the last RING_BYTES bytes of an oversized datagram are stored
            if (len <= RING_BYTES || dgram_pos >= len - RING_BYTES) begin
               ring_copy[written_total[RING_AW-1:0]] = r.data_byte;
               written_total = written_total + 1;
            end
            dgram_pos = (dgram_pos + 1 >= len) ? 0 : dgram_pos + 1;
         end
         FUNC_OPEN: begin
            if (r.reader_index < NUM_READERS)
               reader_pos[r.reader_index] = written_total;
         end
         FUNC_READ: begin
            rd = r.reader_index;
            if (rd >= NUM_READERS) begin
               read_replies.push_back(ring_rsp_type'{read_byte: '0, byte_valid: 1'b0,
                                                     last_result: 1'b1, dropped_bytes: '0});
            end else begin
               lag = written_total - reader_pos[rd];
               if (lag > RING_BYTES) begin
                  skipped = lag - RING_BYTES;
                  if (skipped > 64'hFFFF_FFFF - reader_drops[rd])
                     reader_drops[rd] = '1;
                  else
                     reader_drops[rd] = reader_drops[rd] + skipped[DROP_W-1:0];
                  reader_pos[rd] = written_total - RING_BYTES;
               end
               want  = (r.read_length > READ_BURST) ? READ_BURST : r.read_length;
               avail = written_total - reader_pos[rd];
               n     = (avail < want) ? avail : want;
               if (n == 0)
                  read_replies.push_back(ring_rsp_type'{read_byte: '0, byte_valid: 1'b0,
                                                        last_result: 1'b1,
                                                        dropped_bytes: reader_drops[rd]});
               for (int k = 0; k < n; k++) begin
                  read_replies.push_back(ring_rsp_type'{
                     read_byte: ring_copy[reader_pos[rd][RING_AW-1:0]], byte_valid: 1'b1,
                     last_result: (k == n - 1), dropped_bytes: reader_drops[rd]});
                  reader_pos[rd] = reader_pos[rd] + 1;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         fault_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            model_request(on_offer);
            items_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (request_feed.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               on_offer = request_feed.pop_front();
               req_if.valid           <= 1'b1;
               req_if.func            <= on_offer.func;
               req_if.reader_index    <= on_offer.reader_index;
               req_if.data_byte       <= on_offer.data_byte;
               req_if.datagram_length <= on_offer.datagram_length;
               req_if.read_length     <= on_offer.read_length;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      ring_rsp_type got;
      ring_rsp_type exp_rsp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{read_byte: rsp_if.read_byte, byte_valid: rsp_if.byte_valid,
                    last_result: rsp_if.last_result, dropped_bytes: rsp_if.dropped_bytes};
            if (read_replies.size() == 0) begin
               $error("response transfer with no read pending");
               fault_count++;
            end else begin
               exp_rsp = read_replies.pop_front();
               check_field("read_byte", exp_rsp.read_byte, got.read_byte);
               check_field("byte_valid", exp_rsp.byte_valid, got.byte_valid);
               check_field("last_result", exp_rsp.last_result, got.last_result);
               check_field("dropped_bytes", exp_rsp.dropped_bytes, got.dropped_bytes);
            end
         end
         // one long back-pressure stretch while requests keep coming
         if (!hold_done && items_taken >= hold_at) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      int len;
      int random_items;
      int random_start;

      req_if.valid           = 1'b0;
      req_if.func            = FUNC_WRITE;
      req_if.reader_index    = '0;
      req_if.data_byte       = '0;
      req_if.datagram_length = '0;
      req_if.read_length     = '0;
      rsp_if.ready           = 1'b0;

      // directed
      feed_item(FUNC_READ, 0, 0, 1, 16);          // empty ring
      feed_item(FUNC_WRITE, 0, 8'h00, 0, 0);      // zero length counts as one
      feed_item(FUNC_WRITE, 0, 8'hFF, 1, 0);
      feed_item(FUNC_WRITE, 0, 8'hA5, 4097, 0);   // leading excess byte, skipped
      feed_item(FUNC_WRITE, 0, 8'h5A, 4097, 0);
      feed_item(FUNC_WRITE, 0, 8'h3C, 2, 0);      // length shrinks mid datagram
      feed_item(FUNC_WRITE, 0, 8'h11, 65535, 0);
      feed_item(FUNC_WRITE, 0, 8'h22, 3, 0);
      feed_item(FUNC_WRITE, 0, 8'h33, 3, 31);
      feed_item(FUNC_OPEN, 1, 0, 1, 0);
      feed_item(FUNC_SPARE, 3, 8'hFF, 65535, 31); // unused code, no response
      feed_item(FUNC_READ, 0, 0, 0, 0);           // zero read length
      feed_item(FUNC_READ, 0, 8'hFF, 65535, 31);  // clipped to a full burst
      feed_item(FUNC_READ, 0, 0, 1, 1);
      feed_item(FUNC_READ, 1, 0, 1, 16);
      feed_item(FUNC_WRITE, 2, 8'hC3, 2, 0);
      feed_item(FUNC_WRITE, 2, 8'h96, 2, 0);
      feed_item(FUNC_READ, 1, 0, 1, 17);
      feed_item(FUNC_READ, 3, 0, 1, 16);
      feed_item(FUNC_OPEN, 3, 0, 1, 0);
      feed_item(FUNC_READ, 3, 0, 1, 1);
      feed_item(FUNC_READ, 2, 0, 1, 2);

      // oversized datagram with four leading bytes skipped, cut short by a
      // shorter length, then short datagrams
      feed_item(FUNC_OPEN, 2, 0, 1, 0);
      for (int i = 0; i < 8; i++)
         feed_item(FUNC_WRITE, 0, $urandom_range(0, 255), RING_BYTES + 4, 0);
      feed_item(FUNC_READ, 2, 0, 1, 16);
      feed_item(FUNC_READ, 0, 0, 1, 16);
      for (int i = 0; i < 24; i++)
         feed_item(FUNC_WRITE, 0, $urandom_range(0, 255), 4, 0);
      for (int i = 0; i < NUM_READERS; i++)
         feed_item(FUNC_READ, i, 0, 1, 16);

      // random traffic: mostly whole datagrams and bursts, some noise
      random_start = request_feed.size();
      steady_from  = random_start + 60;
      steady_to    = random_start + 200;
      hold_at      = random_start + 230;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               feed_item(FUNC_WRITE, $urandom_range(0, 3), $urandom_range(0, 255), len,
                         $urandom_range(0, 31));
            random_items += len;
         end else begin
            if (pick < 50)
               feed_item(FUNC_OPEN, $urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 31));
            else if (pick < 85)
               feed_item(FUNC_READ, $urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(1, READ_BURST));
            else if (pick < 91)
               feed_item(FUNC_WRITE, $urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 31));
            else if (pick < 96)
               feed_item(FUNC_READ, $urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 31));
            else
               feed_item(FUNC_SPARE, $urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 31));
            random_items++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (request_feed.size() != 0 || req_if.valid) @(negedge clock);
      while (read_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fault_count == 0 && read_replies.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
